// ===== rtl/core/sla_pkg.sv =====
// Shared constants for the serial line assembler with trailing-control trim.
package sla_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE  = 8'h0A;
    localparam logic [BYTE_W-1:0] PRINTABLE_MIN = 8'h20;
    localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'h00;

endpackage

// ===== rtl/core/serial_line_assembler_trim_unit.sv =====
// Line assembler: stores received bytes, trims trailing bytes below 0x20 at newline, emits the line.
//
//   channel   dir  beat contents
//   s_axis    in   tdata[7:0] = rx_byte
//   m_axis    out  tdata[7:0] = line_byte, tlast = line_last, tuser[0] = line_empty
//
// An ordinary byte is stored and the block stays ready for the next byte. A newline
// starts a backward scan, in which each examined byte takes a read state and a check
// state, and then a readout, in which each emitted byte takes a read state and a load state,
// since the line memory has one registered read port that serves the scan compare and readout.
// The input is not ready from the newline until the last byte is loaded into the
// output register; a stalled output holds the sequencer. Reset returns the write
// position to zero; the memory itself is not cleared.
module serial_line_assembler_trim_unit
    import sla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] line_byte
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] line_empty
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMPTY
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  scan_pos_reg;
    logic [IDX_W-1:0]  emit_pos_reg;
    logic [IDX_W-1:0]  last_pos_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_empty_reg;

    logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              in_beat;
    logic              out_free;
    logic              out_load;
    logic              is_printable;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = out_free && ((state_reg == ST_EMIT_LOAD) || (state_reg == ST_EMPTY));
    assign is_printable  = (rd_data_reg >= PRINTABLE_MIN);

    assign rd_addr = ((state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_LOAD))
                   ? emit_pos_reg : scan_pos_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

    // Single-port line memory: written only while idle, read every cycle.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            line_mem[wr_idx_reg] <= s_axis_tdata;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            scan_pos_reg  <= '0;
            emit_pos_reg  <= '0;
            last_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        if (s_axis_tdata != NEWLINE_CODE)
                        begin
                            if (wr_idx_reg == IDX_W'(LINE_DEPTH - 1))
                                wr_idx_reg <= '0;
                            else
                                wr_idx_reg <= wr_idx_reg + 1'b1;
                        end
                        else
                        begin
                            wr_idx_reg <= '0;
                            // A newline at position zero leaves nothing to keep.
                            if (wr_idx_reg == '0)
                            begin
                                state_reg <= ST_EMPTY;
                            end
                            else
                            begin
                                scan_pos_reg <= wr_idx_reg - 1'b1;
                                state_reg    <= ST_SCAN_RD;
                            end
                        end
                    end
                end

                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CHK;
                end

                ST_SCAN_CHK:
                begin
                    if (is_printable)
                    begin
                        last_pos_reg <= scan_pos_reg;
                        emit_pos_reg <= '0;
                        state_reg    <= ST_EMIT_RD;
                    end
                    else if (scan_pos_reg == '0)
                    begin
                        state_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        scan_pos_reg <= scan_pos_reg - 1'b1;
                        state_reg    <= ST_SCAN_RD;
                    end
                end

                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_LOAD;
                end

                ST_EMIT_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= rd_data_reg;
                        out_last_reg  <= (emit_pos_reg == last_pos_reg);
                        out_empty_reg <= 1'b0;
                        if (emit_pos_reg == last_pos_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            emit_pos_reg <= emit_pos_reg + 1'b1;
                            state_reg    <= ST_EMIT_RD;
                        end
                    end
                end

                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= FILL_BYTE;
                        out_last_reg  <= 1'b1;
                        out_empty_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/sla_checker.sv =====
// Port-level checker for the serial line assembler, bound to the assembler module.
module sla_checker
    import sla_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [BYTE_W-1:0] s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    // A stalled output beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // A newline always starts the scan or the empty-line beat, so the input closes right after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata == NEWLINE_CODE)
        |=> !s_axis_tready)
        else $error("input still ready after newline");

    // After an ordinary byte is stored, the input stays ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata != NEWLINE_CODE)
        |=> s_axis_tready)
        else $error("input not ready after ordinary byte");

    // An empty-line beat is the single, last beat of its line and carries the fill byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser
        |-> m_axis_tlast && (m_axis_tdata == FILL_BYTE))
        else $error("malformed empty-line beat");

endmodule

bind serial_line_assembler_trim_unit sla_checker u_sla_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
